// File: src/lbmc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package lbmc_pkg;

  localparam int POP_W  = 24;
  localparam int POP_F  = 20;
  localparam int RATE_W = 18;
  localparam int RLX_SH = 17;
  localparam int NDIR   = 9;
  localparam int RHO_W  = 28;
  localparam int MOM_W  = 27;
  localparam int UU_W   = 28;
  localparam int FEQ_W  = 40;
  localparam int CFG_AW = 2;

  localparam int LAT_VDIV = 26;
  localparam int LAT_EQ   = 7;
  localparam int LAT_RLX  = 5;
  localparam int T_U      = 1 + LAT_VDIV;
  localparam int T_FEQ    = T_U + LAT_EQ;
  localparam int PIPE_LAT = T_FEQ + LAT_RLX;

  localparam int DIR_X [NDIR] = '{0, 1, 0, -1, 0, 1, -1, -1, 1};
  localparam int DIR_Y [NDIR] = '{0, 0, 1, 0, -1, 1, 1, -1, -1};
  localparam int OPP   [NDIR] = '{0, 3, 4, 1, 2, 7, 8, 5, 6};
  // weight numerator n/36 as a shift: 16, 4, 1
  localparam int WSH   [NDIR] = '{4, 2, 2, 2, 2, 0, 0, 0, 0};

  typedef logic signed [POP_W-1:0]  pop_t;
  typedef pop_t                     pop_arr_t [NDIR];
  typedef logic signed [FEQ_W-1:0]  feq_t;
  typedef feq_t                     feq_arr_t [NDIR];
  typedef logic signed [RATE_W-1:0] rate_t;

  typedef struct packed {
    rate_t even;
    rate_t odd;
  } rate_cfg_t;

  // floor(ex*n*force/12) for the four nonzero cases
  typedef struct packed {
    pop_t g3p;
    pop_t g3n;
    pop_t g12p;
    pop_t g12n;
  } force_t;

  typedef enum logic [CFG_AW-1:0] {
    CFG_RELAX_EVEN = 2'd0,
    CFG_RELAX_ODD  = 2'd1,
    CFG_FORCE      = 2'd2
  } cfg_idx_e;

  localparam rate_t RELAX_EVEN_RST = -18'sd21845;
  localparam rate_t RELAX_ODD_RST  = -18'sd113975;

  function automatic pop_t sat_pop(input logic signed [47:0] v);
    logic signed [47:0] hi;
    logic signed [47:0] lo;
    hi = (48'sd1 <<< (POP_W - 1)) - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) begin
      sat_pop = POP_W'(hi);
    end else if (v < lo) begin
      sat_pop = POP_W'(lo);
    end else begin
      sat_pop = POP_W'(v);
    end
  endfunction

endpackage

`default_nettype wire

// File: src/lbm_d2q9_trt_collision.sv
// channel  | dir | handshake                  | content
// s_axis   | in  | s_axis_tvalid/tready       | nine populations per node
// m_axis   | out | m_axis_tvalid/tready       | nine post values, density, velocity
// cfg      | in  | cfg_valid_i/cfg_ready_o    | register index and data
//
// One node per cycle while m_axis is not stalled; most of the pipe is the velocity
// divider; each equilibrium lane adds 7 stages, a reciprocal multiply for the /9.
// Async active-low reset clears valid bits and skid flag, zeroes force, loads default rates.
// A stall on m_axis freezes the pipe; the input skid holds one more word.
// Config is taken every cycle; force terms are computed from it and registered again.
`timescale 1ns / 1ps
`default_nettype none

module lbm_d2q9_trt_collision (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               s_axis_tvalid,
  output logic                                               s_axis_tready,
  // pop_0 .. pop_8, 24 bits each
  input  logic [lbmc_pkg::NDIR*lbmc_pkg::POP_W-1:0]          s_axis_tdata,
  output logic                                               m_axis_tvalid,
  input  logic                                               m_axis_tready,
  // post_0 .. post_8, density, velocity_x, velocity_y, 24 bits each
  output logic [(lbmc_pkg::NDIR+3)*lbmc_pkg::POP_W-1:0]      m_axis_tdata,
  input  logic                                               cfg_valid_i,
  output logic                                               cfg_ready_o,
  input  logic [lbmc_pkg::CFG_AW-1:0]                        cfg_addr_i,
  input  logic [lbmc_pkg::POP_W-1:0]                         cfg_data_i
);
  import lbmc_pkg::*;

  rate_t       relax_even_q, relax_odd_q;
  pop_t        force_term_q;
  force_t      force_q, force_d;
  rate_cfg_t   rate_cfg;

  logic        skid_v_q;
  pop_arr_t    skid_pop_q, in_pop, st_pop;
  logic        st_v, ce;
  logic [PIPE_LAT:1] vld_q;

  logic signed [RHO_W-1:0] rho_d, mx_d, my_d_r;
  logic signed [MOM_W-1:0] mx_q, my_q;
  logic signed [RHO_W-1:0] rho_q [1:PIPE_LAT-1];
  pop_arr_t    pop_q [1:T_FEQ];
  pop_t        ux_u, uy_u;
  pop_t        ux_dl_q [T_U+1:PIPE_LAT-1];
  pop_t        uy_dl_q [T_U+1:PIPE_LAT-1];
  logic [2*POP_W-1:0] uxsq_q, uysq_q;
  logic [UU_W-1:0]    uu_q;
  feq_arr_t    feq;
  pop_arr_t    post;
  pop_t        density_q, vx_q, vy_q;

  function automatic pop_t div3(input logic signed [26:0] v);
    logic [27:0] x;
    logic [55:0] pr;
    logic [27:0] q;
    x  = 28'($signed(28'(v)) + 28'sd100663296);
    pr = 56'(x) * 56'd178956971;
    q  = pr[56-1:29] & 28'hFFFFFFF;
    div3 = POP_W'($signed(q) - 28'sd33554432);
  endfunction

  // config
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      relax_even_q <= RELAX_EVEN_RST;
      relax_odd_q  <= RELAX_ODD_RST;
      force_term_q <= '0;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_addr_i))
        CFG_RELAX_EVEN: relax_even_q <= cfg_data_i[RATE_W-1:0];
        CFG_RELAX_ODD:  relax_odd_q  <= cfg_data_i[RATE_W-1:0];
        CFG_FORCE:      force_term_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    pop_t a, b, c;
    a = div3(27'(force_term_q));
    b = div3(27'(force_term_q) + 27'sd2);
    c = div3(27'(force_term_q) + 27'sd11);
    force_d.g3p  = a;
    force_d.g3n  = -b;
    force_d.g12p = a >>> 2;
    force_d.g12n = -(c >>> 2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      force_q <= '0;
    end else begin
      force_q <= force_d;
    end
  end

  assign rate_cfg.even = relax_even_q;
  assign rate_cfg.odd  = relax_odd_q;

  // input skid and pipe control
  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      in_pop[k] = s_axis_tdata[k*POP_W +: POP_W];
    end
  end

  assign s_axis_tready = !skid_v_q;
  assign ce     = !vld_q[PIPE_LAT] || m_axis_tready;
  assign st_pop = skid_v_q ? skid_pop_q : in_pop;
  assign st_v   = skid_v_q || s_axis_tvalid;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_v_q <= 1'b0;
      vld_q    <= '0;
    end else begin
      if (ce) begin
        skid_v_q <= 1'b0;
        vld_q    <= {vld_q[PIPE_LAT-1:1], st_v};
      end else if (s_axis_tvalid && s_axis_tready) begin
        skid_v_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (!ce && s_axis_tvalid && s_axis_tready) begin
      skid_pop_q <= in_pop;
    end
  end

  always_comb begin
    rho_d  = '0;
    mx_d   = '0;
    my_d_r = '0;
    for (int k = 0; k < NDIR; k++) begin
      rho_d = rho_d + RHO_W'(st_pop[k]);
      if (DIR_X[k] > 0) begin
        mx_d = mx_d + RHO_W'(st_pop[k]);
      end else if (DIR_X[k] < 0) begin
        mx_d = mx_d - RHO_W'(st_pop[k]);
      end
      if (DIR_Y[k] > 0) begin
        my_d_r = my_d_r + RHO_W'(st_pop[k]);
      end else if (DIR_Y[k] < 0) begin
        my_d_r = my_d_r - RHO_W'(st_pop[k]);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce) begin
      pop_q[1] <= st_pop;
      for (int t = 2; t <= T_FEQ; t++) begin
        pop_q[t] <= pop_q[t-1];
      end
      rho_q[1] <= rho_d;
      for (int t = 2; t <= PIPE_LAT-1; t++) begin
        rho_q[t] <= rho_q[t-1];
      end
      mx_q <= MOM_W'(mx_d);
      my_q <= MOM_W'(my_d_r);
      ux_dl_q[T_U+1] <= ux_u;
      uy_dl_q[T_U+1] <= uy_u;
      for (int t = T_U+2; t <= PIPE_LAT-1; t++) begin
        ux_dl_q[t] <= ux_dl_q[t-1];
        uy_dl_q[t] <= uy_dl_q[t-1];
      end
      uxsq_q <= (2*POP_W)'(ux_u * ux_u);
      uysq_q <= (2*POP_W)'(uy_u * uy_u);
      uu_q   <= UU_W'(((2*POP_W+1)'(uxsq_q) + (2*POP_W+1)'(uysq_q)) >> POP_F);
      density_q <= sat_pop(48'(rho_q[PIPE_LAT-1]));
      vx_q      <= ux_dl_q[PIPE_LAT-1];
      vy_q      <= uy_dl_q[PIPE_LAT-1];
    end
  end

  lbmc_vdiv u_vdiv_x (
    .clk_i (clk_i),
    .ce_i  (ce),
    .mom_i (mx_q),
    .rho_i (rho_q[1]),
    .u_o   (ux_u)
  );

  lbmc_vdiv u_vdiv_y (
    .clk_i (clk_i),
    .ce_i  (ce),
    .mom_i (my_q),
    .rho_i (rho_q[1]),
    .u_o   (uy_u)
  );

  for (genvar k = 0; k < NDIR; k++) begin : g_lane
    lbmc_eq_lane u_lane (
      .clk_i (clk_i),
      .ce_i  (ce),
      .ex_i  (2'(DIR_X[k])),
      .ey_i  (2'(DIR_Y[k])),
      .wsh_i (3'(WSH[k])),
      .ux_i  (ux_u),
      .uy_i  (uy_u),
      .uu_i  (uu_q),
      .rho_i (rho_q[T_U+3]),
      .feq_o (feq[k])
    );
  end

  lbmc_relax u_relax (
    .clk_i  (clk_i),
    .ce_i   (ce),
    .cfg_i  (rate_cfg),
    .frc_i  (force_q),
    .p_i    (pop_q[T_FEQ]),
    .feq_i  (feq),
    .post_o (post)
  );

  assign m_axis_tvalid = vld_q[PIPE_LAT];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      m_axis_tdata[k*POP_W +: POP_W] = post[k];
    end
    m_axis_tdata[NDIR*POP_W +: POP_W]     = density_q;
    m_axis_tdata[(NDIR+1)*POP_W +: POP_W] = vx_q;
    m_axis_tdata[(NDIR+2)*POP_W +: POP_W] = vy_q;
  end

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !ce |=> m_axis_tvalid)
    else $error("output word dropped during stall");

  a_skid_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready && !ce) |=> skid_v_q)
    else $error("stalled input word not held in skid");

  a_zero_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && density_q <= 0) |-> (vx_q == '0 && vy_q == '0))
    else $error("velocity not zero for nonpositive density");

endmodule

`default_nettype wire

// File: src/lbmc_vdiv.sv
`timescale 1ns / 1ps
`default_nettype none

module lbmc_vdiv (
  input  logic                                 clk_i,
  input  logic                                 ce_i,
  input  logic signed [lbmc_pkg::MOM_W-1:0]    mom_i,
  input  logic signed [lbmc_pkg::RHO_W-1:0]    rho_i,
  output lbmc_pkg::pop_t                       u_o
);
  import lbmc_pkg::*;

  localparam int QW = POP_W;
  localparam int DW = RHO_W - 1;
  localparam int RW = DW + QW;

  logic [RW-1:0] rem_q  [0:QW];
  logic [DW-1:0] d_q    [0:QW];
  logic [QW-1:0] q_q    [0:QW];
  logic          neg_q  [0:QW];
  logic          ovf_q  [0:QW];
  logic          zero_q [0:QW];
  logic [RW-1:0] rem_d  [1:QW];
  logic [QW:1]   bit_d;
  logic [MOM_W-1:0] mag;
  logic [QW-1:0] qv;
  pop_t          u_q;

  assign mag = mom_i[MOM_W-1] ? MOM_W'(-mom_i) : MOM_W'(mom_i);

  always_comb begin
    logic [RW-1:0] dsh;
    for (int j = 1; j <= QW; j++) begin
      dsh = RW'(d_q[j-1]) << (QW - j);
      bit_d[j] = rem_q[j-1] >= dsh;
      rem_d[j] = bit_d[j] ? rem_q[j-1] - dsh : rem_q[j-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      rem_q[0]  <= RW'(mag) << POP_F;
      d_q[0]    <= rho_i[DW-1:0];
      q_q[0]    <= '0;
      neg_q[0]  <= mom_i[MOM_W-1];
      zero_q[0] <= rho_i[RHO_W-1] || (rho_i == '0);
      ovf_q[0]  <= (DW+4)'(mag) >= {rho_i[DW-1:0], 4'b0000};
      for (int j = 1; j <= QW; j++) begin
        rem_q[j]  <= rem_d[j];
        d_q[j]    <= d_q[j-1];
        q_q[j]    <= {q_q[j-1][QW-2:0], bit_d[j]};
        neg_q[j]  <= neg_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
        zero_q[j] <= zero_q[j-1];
      end
    end
  end

  assign qv = q_q[QW];

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      if (zero_q[QW]) begin
        u_q <= '0;
      end else if (neg_q[QW]) begin
        if (ovf_q[QW] || (qv[QW-1] && |qv[QW-2:0])) begin
          u_q <= {1'b1, {(QW-1){1'b0}}};
        end else begin
          u_q <= QW'(~qv + 1'b1);
        end
      end else begin
        if (ovf_q[QW] || qv[QW-1]) begin
          u_q <= {1'b0, {(QW-1){1'b1}}};
        end else begin
          u_q <= qv;
        end
      end
    end
  end

  assign u_o = u_q;

endmodule

`default_nettype wire

// File: src/lbmc_eq_lane.sv
`timescale 1ns / 1ps
`default_nettype none

module lbmc_eq_lane (
  input  logic                               clk_i,
  input  logic                               ce_i,
  input  logic signed [1:0]                  ex_i,
  input  logic signed [1:0]                  ey_i,
  input  logic [2:0]                         wsh_i,
  input  lbmc_pkg::pop_t                     ux_i,
  input  lbmc_pkg::pop_t                     uy_i,
  input  logic [lbmc_pkg::UU_W-1:0]          uu_i,
  input  logic signed [lbmc_pkg::RHO_W-1:0]  rho_i,
  output lbmc_pkg::feq_t                     feq_o
);
  import lbmc_pkg::*;

  localparam int EU_W    = POP_W + 2;
  localparam int SQ_W    = 2 * EU_W;
  localparam int E2_W    = 2 * POP_W + 1 - POP_F;
  localparam int B2_W    = 36;
  localparam int BL_W    = 18;
  localparam int PR_W    = 64;
  localparam int SH_DIV  = POP_F + 3;
  localparam int ZW      = 41;
  localparam int BIAS_SH = 36;
  localparam int HALF    = 21;
  localparam int PP_W    = 2 * HALF;
  localparam int FP_W    = 2 * ZW;
  localparam int RCP_SH  = 44;
  // ceil(2^44 / 9), exact for the biased range below 2^41
  localparam logic [ZW-1:0] RCP9 = 41'd1954687338269;

  function automatic logic signed [EU_W-1:0] proj(input logic signed [1:0] e, input pop_t u);
    logic signed [EU_W-1:0] w;
    w = EU_W'(u);
    case (e)
      2'sb01:  proj = w;
      2'sb11:  proj = -w;
      default: proj = '0;
    endcase
  endfunction

  logic signed [EU_W-1:0]        eu_q;
  logic signed [EU_W-1:0]        eu2_q;
  logic signed [SQ_W-1:0]        eusq_q;
  logic signed [B2_W-1:0]        b2_d, b2_q;
  logic signed [RHO_W+BL_W:0]    plo_q;
  logic signed [RHO_W+BL_W-1:0]  phi_q;
  logic [ZW-1:0]                 z_d;
  logic [ZW-1:0]                 z_q;
  logic [PP_W-1:0]               pp_hh_q, pp_hl_q, pp_lh_q, pp_ll_q;
  logic [ZW-1:0]                 q_d;
  logic [ZW-1:0]                 qa_q;

  always_comb begin
    logic signed [B2_W-1:0] eu_e, sq_e, uu_e;
    eu_e = B2_W'(eu2_q);
    sq_e = $signed(B2_W'(eusq_q[POP_F +: E2_W]));
    uu_e = $signed(B2_W'(uu_i));
    b2_d = B2_W'((B2_W'(2) <<< POP_F) + 6 * eu_e + 9 * sq_e - 3 * uu_e);
  end

  always_comb begin
    logic signed [PR_W-1:0]   prod;
    logic signed [PR_W+3:0]   shd;
    logic signed [PR_W+3:0]   y;
    prod = (PR_W'(phi_q) <<< BL_W) + PR_W'(plo_q);
    shd  = (PR_W+4)'(prod) <<< wsh_i;
    y    = shd >>> SH_DIV;
    z_d  = ZW'(y) + (ZW'(9) << BIAS_SH);
  end

  // z/9 by reciprocal multiply, split in halves over two stages
  always_comb begin
    logic [FP_W-1:0] full;
    full = (FP_W'(pp_hh_q) << (2 * HALF)) + (FP_W'(pp_hl_q) << HALF)
         + (FP_W'(pp_lh_q) << HALF) + FP_W'(pp_ll_q);
    q_d  = ZW'(full >> RCP_SH);
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      eu_q    <= proj(ex_i, ux_i) + proj(ey_i, uy_i);
      eusq_q  <= eu_q * eu_q;
      eu2_q   <= eu_q;
      b2_q    <= b2_d;
      plo_q   <= rho_i * $signed({1'b0, b2_q[BL_W-1:0]});
      phi_q   <= rho_i * $signed(b2_q[B2_W-1:BL_W]);
      z_q     <= z_d;
      pp_hh_q <= PP_W'(z_q[ZW-1:HALF]) * PP_W'(RCP9[ZW-1:HALF]);
      pp_hl_q <= PP_W'(z_q[ZW-1:HALF]) * PP_W'(RCP9[HALF-1:0]);
      pp_lh_q <= PP_W'(z_q[HALF-1:0]) * PP_W'(RCP9[ZW-1:HALF]);
      pp_ll_q <= PP_W'(z_q[HALF-1:0]) * PP_W'(RCP9[HALF-1:0]);
      qa_q    <= q_d;
    end
  end

  assign feq_o = FEQ_W'(qa_q - (ZW'(1) << BIAS_SH));

endmodule

`default_nettype wire

// File: src/lbmc_relax.sv
`timescale 1ns / 1ps
`default_nettype none

module lbmc_relax (
  input  logic                  clk_i,
  input  logic                  ce_i,
  input  lbmc_pkg::rate_cfg_t   cfg_i,
  input  lbmc_pkg::force_t      frc_i,
  input  lbmc_pkg::pop_arr_t    p_i,
  input  lbmc_pkg::feq_arr_t    feq_i,
  output lbmc_pkg::pop_arr_t    post_o
);
  import lbmc_pkg::*;

  localparam int NEQ_W = 42;
  localparam int HW    = 21;
  localparam int PL_W  = RATE_W + HW + 1;
  localparam int PH_W  = RATE_W + NEQ_W - HW;
  localparam int SUM_W = 64;
  localparam int RL_W  = SUM_W - RLX_SH;

  logic signed [NEQ_W-1:0] neq_q [NDIR];
  logic signed [NEQ_W-1:0] ev_q  [NDIR];
  logic signed [NEQ_W-1:0] od_q  [NDIR];
  logic signed [PL_W-1:0]  pel_q [NDIR];
  logic signed [PH_W-1:0]  peh_q [NDIR];
  logic signed [PL_W-1:0]  pol_q [NDIR];
  logic signed [PH_W-1:0]  poh_q [NDIR];
  logic signed [RL_W-1:0]  rl_q  [NDIR];
  pop_t                    fk    [NDIR];
  pop_arr_t                p1_q, p2_q, p3_q, p4_q, post_q;
  logic signed [SUM_W-1:0] s_d   [NDIR];

  always_comb begin
    for (int k = 0; k < NDIR; k++) begin
      if (DIR_X[k] == 0) begin
        fk[k] = '0;
      end else if (WSH[k] == 2) begin
        fk[k] = (DIR_X[k] > 0) ? frc_i.g3p : frc_i.g3n;
      end else begin
        fk[k] = (DIR_X[k] > 0) ? frc_i.g12p : frc_i.g12n;
      end
      s_d[k] = (SUM_W'(peh_q[k]) <<< HW) + SUM_W'(pel_q[k])
             + (SUM_W'(poh_q[k]) <<< HW) + SUM_W'(pol_q[k]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ce_i) begin
      p1_q <= p_i;
      p2_q <= p1_q;
      p3_q <= p2_q;
      p4_q <= p3_q;
      for (int k = 0; k < NDIR; k++) begin
        neq_q[k] <= NEQ_W'(p_i[k]) - NEQ_W'(feq_i[k]);
        ev_q[k]  <= neq_q[k] + neq_q[OPP[k]];
        od_q[k]  <= neq_q[k] - neq_q[OPP[k]];
        pel_q[k] <= $signed(cfg_i.even) * $signed({1'b0, ev_q[k][HW-1:0]});
        peh_q[k] <= $signed(cfg_i.even) * $signed(ev_q[k][NEQ_W-1:HW]);
        pol_q[k] <= $signed(cfg_i.odd) * $signed({1'b0, od_q[k][HW-1:0]});
        poh_q[k] <= $signed(cfg_i.odd) * $signed(od_q[k][NEQ_W-1:HW]);
        rl_q[k]  <= RL_W'(s_d[k] >>> RLX_SH);
        post_q[k] <= sat_pop(48'(p4_q[k]) + 48'(rl_q[k]) + 48'(fk[k]));
      end
    end
  end

  assign post_o = post_q;

endmodule

`default_nettype wire
